### rtl/cvr_pkg.sv
// shared types and constants for the collision velocity response pipeline
`timescale 1ns / 1ps

package cvr_pkg;

    // quotient bits of the mass ratio, Q1.32
    localparam int QW = 33;
    // magnitude of the projected velocity difference, below 2^48
    localparam int MW = 48;
    // signed projected velocity difference
    localparam int DW = 49;
    // widened result before clamping
    localparam int RW = 38;

    localparam logic [QW:0] RATIO_ONE = 34'h1_0000_0000;

    typedef struct packed {
        logic [QW-1:0] divisor;
        logic [QW-1:0] rem;
        logic [QW-1:0] quot;
    } cvr_div_t;

    typedef struct packed {
        logic signed [31:0]   vel_a;
        logic signed [31:0]   vel_b;
        logic signed [DW-1:0] diff;
        logic [31:0]          ee;
        logic                 upd_a;
        logic                 upd_b;
        logic                 err;
    } cvr_side_t;

endpackage

### rtl/cvr_div_stage.sv
// one restoring division step with its pipeline register
`timescale 1ns / 1ps

module cvr_div_stage
    import cvr_pkg::*;
#(
    parameter int BIT = 32
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      en,
    input  logic      in_valid,
    input  cvr_div_t  in_div,
    input  cvr_side_t in_side,
    output logic      out_valid,
    output cvr_div_t  out_div,
    output cvr_side_t out_side
);

    localparam bit FIRST = (BIT == QW - 1);

    logic      valid_reg;
    cvr_div_t  div_reg;
    cvr_side_t side_reg;
    cvr_div_t  div_next;
    logic [QW:0] trial;
    logic [QW:0] diff;
    logic        ge;

    always_comb
    begin
        // first step starts from the unshifted numerator
        if (FIRST)
        begin
            trial = {1'b0, in_div.rem};
        end
        else
        begin
            trial = {in_div.rem, 1'b0};
        end
        ge   = (trial >= {1'b0, in_div.divisor});
        diff = trial - {1'b0, in_div.divisor};
        div_next         = in_div;
        div_next.rem     = ge ? diff[QW-1:0] : trial[QW-1:0];
        div_next.quot[BIT] = ge;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            div_reg  <= div_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_div   = div_reg;
    assign out_side  = side_reg;

endmodule

### rtl/cvr_divider.sv
// pipelined restoring divider for the mass ratio, one quotient bit per stage
`timescale 1ns / 1ps

module cvr_divider
    import cvr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      en,
    input  logic      in_valid,
    input  cvr_div_t  in_div,
    input  cvr_side_t in_side,
    output logic      out_valid,
    output cvr_div_t  out_div,
    output cvr_side_t out_side
);

    logic      v  [0:QW];
    cvr_div_t  dv [0:QW];
    cvr_side_t sd [0:QW];

    assign v[0]  = in_valid;
    assign dv[0] = in_div;
    assign sd[0] = in_side;

    for (genvar g = 0; g < QW; g++)
    begin : g_step
        cvr_div_stage #(
            .BIT(QW - 1 - g)
        ) u_stage (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .in_valid (v[g]),
            .in_div   (dv[g]),
            .in_side  (sd[g]),
            .out_valid(v[g+1]),
            .out_div  (dv[g+1]),
            .out_side (sd[g+1])
        );
    end

    assign out_valid = v[QW];
    assign out_div   = dv[QW];
    assign out_side  = sd[QW];

endmodule

### rtl/cvr_scale.sv
// restitution factor, scaled delta with rounding and saturating add for one body
`timescale 1ns / 1ps

module cvr_scale
    import cvr_pkg::*;
(
    input  logic               clk,
    input  logic               en,
    input  logic [QW-1:0]      ratio,
    input  logic [31:0]        ee,
    input  logic [MW-1:0]      mag,
    input  logic               neg,
    input  logic signed [31:0] vel,
    input  logic               upd,
    output logic signed [31:0] new_vel,
    output logic               sat
);

    // stage 1: k = r + ee*r/2^32
    logic [64:0]      ee_prod;
    logic [QW:0]      k_next;
    logic [QW:0]      k1_reg;
    logic [MW-1:0]    mag1_reg;
    logic             neg1_reg;
    logic signed [31:0] vel1_reg;
    logic             upd1_reg;

    always_comb
    begin
        ee_prod = {33'd0, ee} * {32'd0, ratio};
        k_next  = {1'b0, ratio} + {1'b0, ee_prod[64:32]};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            k1_reg   <= k_next;
            mag1_reg <= mag;
            neg1_reg <= neg;
            vel1_reg <= vel;
            upd1_reg <= upd;
        end
    end

    // stage 2: partial products of |d| * k
    logic [57:0]      plo_next;
    logic [57:0]      phi_next;
    logic [57:0]      plo2_reg;
    logic [57:0]      phi2_reg;
    logic             neg2_reg;
    logic signed [31:0] vel2_reg;
    logic             upd2_reg;

    always_comb
    begin
        plo_next = {34'd0, mag1_reg[23:0]} * {24'd0, k1_reg};
        phi_next = {34'd0, mag1_reg[47:24]} * {24'd0, k1_reg};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            plo2_reg <= plo_next;
            phi2_reg <= phi_next;
            neg2_reg <= neg1_reg;
            vel2_reg <= vel1_reg;
            upd2_reg <= upd1_reg;
        end
    end

    // stage 3: sum, round half up on the magnitude, drop 46 bits
    logic [81:0]      full;
    logic [35:0]      q_next;
    logic [35:0]      q3_reg;
    logic             neg3_reg;
    logic signed [31:0] vel3_reg;
    logic             upd3_reg;

    always_comb
    begin
        full   = {24'd0, plo2_reg} + {phi2_reg, 24'd0} + (82'd1 << 45);
        q_next = full[81:46];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q3_reg   <= q_next;
            neg3_reg <= neg2_reg;
            vel3_reg <= vel2_reg;
            upd3_reg <= upd2_reg;
        end
    end

    // stage 4: signed add and clamp
    logic signed [RW-1:0] delta;
    logic signed [RW-1:0] sum;
    logic signed [31:0]   vel_next;
    logic                 sat_next;
    logic signed [31:0]   vel4_reg;
    logic                 sat4_reg;

    always_comb
    begin
        delta = neg3_reg ? -$signed({2'b00, q3_reg}) : $signed({2'b00, q3_reg});
        sum   = $signed({{(RW-32){vel3_reg[31]}}, vel3_reg}) + delta;
        vel_next = vel3_reg;
        sat_next = 1'b0;
        if (upd3_reg)
        begin
            if (sum > $signed({{(RW-32){1'b0}}, 32'h7FFF_FFFF}))
            begin
                vel_next = 32'sh7FFF_FFFF;
                sat_next = 1'b1;
            end
            else if (sum < $signed({{(RW-32){1'b1}}, 32'h8000_0000}))
            begin
                vel_next = $signed(32'h8000_0000);
                sat_next = 1'b1;
            end
            else
            begin
                vel_next = sum[31:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vel4_reg <= vel_next;
            sat4_reg <= sat_next;
        end
    end

    assign new_vel = vel4_reg;
    assign sat     = sat4_reg;

endmodule

### rtl/collision_velocity_response_unit.sv
// top level: 1-d restitution collision response for one velocity component
// throughput: one item per cycle while results are taken;
// the 33-step mass-ratio divider sets the depth
// the whole pipeline advances together and holds while a result is not taken
// reset (rst_n low, asynchronous) clears all valid bits; no results pending
`timescale 1ns / 1ps

module collision_velocity_response_unit
    import cvr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] vel_a,
    input  logic signed [31:0] vel_b,
    input  logic signed [15:0] normal_comp,
    input  logic [31:0]        mass_a,
    input  logic [31:0]        mass_b,
    input  logic               static_a,
    input  logic               static_b,
    input  logic [15:0]        elast_a,
    input  logic [15:0]        elast_b,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] new_vel_a,
    output logic signed [31:0] new_vel_b,
    output logic               zero_mass_error,
    output logic               saturated
);

    logic en;
    assign en       = !out_valid || out_ready;
    assign in_ready = en;

    // front stage: masses, projection, elasticity product
    logic [31:0]          mx;
    logic [31:0]          my;
    logic [QW-1:0]        mm;
    logic signed [32:0]   vsum;
    logic signed [DW-1:0] proj;
    cvr_div_t             div_next;
    cvr_side_t            side_next;
    logic                 s0_valid_reg;
    cvr_div_t             s0_div_reg;
    cvr_side_t            s0_side_reg;

    always_comb
    begin
        if (static_a)
        begin
            mx = 32'd1;
            my = 32'd0;
        end
        else if (static_b)
        begin
            mx = 32'd0;
            my = 32'd1;
        end
        else
        begin
            mx = mass_a;
            my = mass_b;
        end
        mm   = {1'b0, mx} + {1'b0, my};
        vsum = $signed({vel_a[31], vel_a}) + $signed({vel_b[31], vel_b});
        proj = $signed({{(DW-33){vsum[32]}}, vsum})
             * $signed({{(DW-16){normal_comp[15]}}, normal_comp});

        div_next.divisor = (mm == '0) ? QW'(1) : mm;
        div_next.rem     = {1'b0, my};
        div_next.quot    = '0;

        side_next.vel_a = vel_a;
        side_next.vel_b = vel_b;
        side_next.diff  = -proj;
        side_next.ee    = {16'd0, elast_a} * {16'd0, elast_b};
        side_next.err   = !static_a && !static_b && (mm == '0);
        side_next.upd_a = !static_a && !side_next.err;
        side_next.upd_b = !static_b && !side_next.err;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s0_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_div_reg  <= div_next;
            s0_side_reg <= side_next;
        end
    end

    // mass ratio for body A; body B follows from the remainder
    logic      dv_valid;
    cvr_div_t  dv_div;
    cvr_side_t dv_side;

    cvr_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (s0_valid_reg),
        .in_div   (s0_div_reg),
        .in_side  (s0_side_reg),
        .out_valid(dv_valid),
        .out_div  (dv_div),
        .out_side (dv_side)
    );

    logic [QW:0]     rb_wide;
    logic [QW-1:0]   rb_next;
    logic [MW-1:0]   mag_next;
    logic [DW-1:0]   neg_diff;
    logic            f_valid_reg;
    logic [QW-1:0]   f_ra_reg;
    logic [QW-1:0]   f_rb_reg;
    logic [MW-1:0]   f_mag_reg;
    logic            f_neg_reg;
    cvr_side_t       f_side_reg;

    always_comb
    begin
        // floor(mx/mm) = 1 - ceil(my/mm) in Q1.32
        rb_wide  = RATIO_ONE - {1'b0, dv_div.quot} - {{QW{1'b0}}, (dv_div.rem != '0)};
        rb_next  = rb_wide[QW-1:0];
        neg_diff = -dv_side.diff;
        mag_next = dv_side.diff[DW-1] ? neg_diff[MW-1:0] : dv_side.diff[MW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            f_valid_reg <= dv_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f_ra_reg   <= dv_div.quot;
            f_rb_reg   <= rb_next;
            f_mag_reg  <= mag_next;
            f_neg_reg  <= dv_side.diff[DW-1];
            f_side_reg <= dv_side;
        end
    end

    logic sat_a;
    logic sat_b;

    cvr_scale u_scale_a (
        .clk    (clk),
        .en     (en),
        .ratio  (f_ra_reg),
        .ee     (f_side_reg.ee),
        .mag    (f_mag_reg),
        .neg    (f_neg_reg),
        .vel    (f_side_reg.vel_a),
        .upd    (f_side_reg.upd_a),
        .new_vel(new_vel_a),
        .sat    (sat_a)
    );

    // body B moves against the difference
    cvr_scale u_scale_b (
        .clk    (clk),
        .en     (en),
        .ratio  (f_rb_reg),
        .ee     (f_side_reg.ee),
        .mag    (f_mag_reg),
        .neg    (!f_neg_reg),
        .vel    (f_side_reg.vel_b),
        .upd    (f_side_reg.upd_b),
        .new_vel(new_vel_b),
        .sat    (sat_b)
    );

    // valid and error flag alongside the four scale stages
    logic sc_valid_reg [0:3];
    logic sc_err_reg   [0:3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                sc_valid_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            sc_valid_reg[0] <= f_valid_reg;
            for (int i = 1; i < 4; i++)
            begin
                sc_valid_reg[i] <= sc_valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sc_err_reg[0] <= f_side_reg.err;
            for (int i = 1; i < 4; i++)
            begin
                sc_err_reg[i] <= sc_err_reg[i-1];
            end
        end
    end

    assign out_valid       = sc_valid_reg[3];
    assign zero_mass_error = sc_err_reg[3];
    assign saturated       = sat_a | sat_b;

`ifndef ASSERT_OFF
    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        dv_valid |-> (dv_div.rem < dv_div.divisor))
        else $error("divider remainder not below divisor");

    a_ratio_sum: assert property (@(posedge clk) disable iff (!rst_n)
        f_valid_reg |-> (({1'b0, f_ra_reg} + {1'b0, f_rb_reg}) <= RATIO_ONE))
        else $error("mass ratios exceed one");

    a_err_nosat: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && zero_mass_error) |-> !saturated)
        else $error("saturation flagged on zero mass item");
`endif

endmodule
